@@ sv/wesd_pkg.sv @@
// ----------------------------------------------------------------------------
// wesd_pkg
// Shared codes, register indexes and controller/datapath link types for the
// window edge snap drag engine.
// ----------------------------------------------------------------------------
`default_nettype none

package wesd_pkg;

  localparam int CMD_W      = 3;
  localparam int MODE_W     = 2;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int SNAP_W     = 10;

  // input commands
  localparam logic [CMD_W-1:0] CMD_START   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_MOTION  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEER    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FINISH  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd4;

  // drag modes
  localparam logic [MODE_W-1:0] MODE_MOVE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RESIZE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ICON   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BAD    = 2'd3;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_MOVE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RESIZE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ICON    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SNAP_DISTANCE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DIMENSION   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIMENSION   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLICK_THRESHOLD = 3'd5;

  // configuration reset values
  localparam logic [SNAP_W-1:0]     RST_SNAP_DISTANCE   = 10'd0;
  localparam logic [CFG_DATA_W-1:0] RST_SCREEN_WIDTH    = 16'd0;
  localparam logic [CFG_DATA_W-1:0] RST_SCREEN_HEIGHT   = 16'd0;
  localparam logic [CFG_DATA_W-1:0] RST_MIN_DIMENSION   = 16'd1;
  localparam logic [CFG_DATA_W-1:0] RST_MAX_DIMENSION   = 16'd65535;
  localparam logic [CFG_DATA_W-1:0] RST_CLICK_THRESHOLD = 16'd16;

  // pointer travel per axis below which a release is tested for a click
  localparam int CLICK_SPAN = 256;
  localparam int CLICK_BITS = 9;

  // datapath operations
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE   = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD   = 4'd1;
  localparam logic [OP_W-1:0] OP_START  = 4'd2;
  localparam logic [OP_W-1:0] OP_MOTION = 4'd3;
  localparam logic [OP_W-1:0] OP_CLAMP  = 4'd4;
  localparam logic [OP_W-1:0] OP_PREP   = 4'd5;
  localparam logic [OP_W-1:0] OP_FOLD   = 4'd6;
  localparam logic [OP_W-1:0] OP_FIN1   = 4'd7;
  localparam logic [OP_W-1:0] OP_FIN2   = 4'd8;
  localparam logic [OP_W-1:0] OP_FIN3   = 4'd9;
  localparam logic [OP_W-1:0] OP_END    = 4'd11;
  localparam logic [OP_W-1:0] OP_REL    = 4'd12;
  localparam logic [OP_W-1:0] OP_EMIT   = 4'd13;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [MODE_W-1:0] mode;
    logic              active;
    logic [MODE_W-1:0] drag_mode;
    logic              snap_zero;
  } status_t;

endpackage

`default_nettype wire

@@ sv/wesd_if.sv @@
// ----------------------------------------------------------------------------
// wesd_if
// Valid/ready channel interfaces: drag items in, results out, register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface wesd_in_if #(parameter int COORD_BITS = 16) ();
  logic                                 valid;
  logic                                 ready;
  logic [wesd_pkg::CMD_W-1:0]           cmd;
  logic [wesd_pkg::MODE_W-1:0]          mode;
  logic signed [COORD_BITS-1:0]         pointer_x;
  logic signed [COORD_BITS-1:0]         pointer_y;
  logic signed [COORD_BITS-1:0]         rect_x;
  logic signed [COORD_BITS-1:0]         rect_y;
  logic [COORD_BITS-1:0]                rect_w;
  logic [COORD_BITS-1:0]                rect_h;

  modport source (output valid, cmd, mode, pointer_x, pointer_y, rect_x, rect_y,
                  rect_w, rect_h, input ready);
  modport sink (input valid, cmd, mode, pointer_x, pointer_y, rect_x, rect_y,
                rect_w, rect_h, output ready);
endinterface

interface wesd_out_if #(parameter int COORD_BITS = 16) ();
  logic                          valid;
  logic                          ready;
  logic [wesd_pkg::KIND_W-1:0]   result_kind;
  logic signed [COORD_BITS:0]    out_x;
  logic signed [COORD_BITS:0]    out_y;
  logic [COORD_BITS-1:0]         out_w;
  logic [COORD_BITS-1:0]         out_h;
  logic                          is_click;

  modport source (output valid, result_kind, out_x, out_y, out_w, out_h, is_click,
                  input ready);
  modport sink (input valid, result_kind, out_x, out_y, out_w, out_h, is_click,
                output ready);
endinterface

interface wesd_cfg_if ();
  logic                              valid;
  logic                              ready;
  logic [wesd_pkg::CFG_IDX_W-1:0]    index;
  logic [wesd_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ sv/wesd_ctrl.sv @@
// ----------------------------------------------------------------------------
// wesd_ctrl
// Sequencer: accepts one item, walks the datapath through its steps and
// owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module wesd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  wesd_pkg::status_t sts,
  output wesd_pkg::ctl_t    ctl
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EXEC   = 4'd1;
  localparam logic [3:0] S_MOTION = 4'd2;
  localparam logic [3:0] S_CLAMP  = 4'd3;
  localparam logic [3:0] S_PEER   = 4'd4;
  localparam logic [3:0] S_FIN1   = 4'd5;
  localparam logic [3:0] S_FIN2   = 4'd6;
  localparam logic [3:0] S_FIN3   = 4'd7;
  localparam logic [3:0] S_REL    = 4'd9;
  localparam logic [3:0] S_EMIT   = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       emit;

  always_comb begin
    state_nxt = state_r;
    ctl.op    = wesd_pkg::OP_NONE;
    emit      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.op    = wesd_pkg::OP_LOAD;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        if (sts.cmd == wesd_pkg::CMD_START) begin
          if (sts.mode != wesd_pkg::MODE_BAD) begin
            ctl.op    = wesd_pkg::OP_START;
            state_nxt = S_MOTION;
          end
        end else if (sts.active) begin
          case (sts.cmd)
            wesd_pkg::CMD_MOTION: state_nxt = S_MOTION;
            wesd_pkg::CMD_PEER: begin
              if (sts.drag_mode != wesd_pkg::MODE_ICON && !sts.snap_zero) begin
                ctl.op    = wesd_pkg::OP_PREP;
                state_nxt = S_PEER;
              end
            end
            wesd_pkg::CMD_FINISH: state_nxt = S_FIN1;
            wesd_pkg::CMD_RELEASE: begin
              ctl.op = wesd_pkg::OP_END;
              if (sts.drag_mode == wesd_pkg::MODE_ICON) begin
                state_nxt = S_REL;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_MOTION: begin
        ctl.op    = wesd_pkg::OP_MOTION;
        state_nxt = S_CLAMP;
      end
      S_CLAMP: begin
        ctl.op    = wesd_pkg::OP_CLAMP;
        state_nxt = S_IDLE;
      end
      S_PEER: begin
        ctl.op    = wesd_pkg::OP_FOLD;
        state_nxt = S_IDLE;
      end
      S_FIN1: begin
        ctl.op    = wesd_pkg::OP_FIN1;
        state_nxt = S_FIN2;
      end
      S_FIN2: begin
        ctl.op    = wesd_pkg::OP_FIN2;
        state_nxt = S_FIN3;
      end
      S_FIN3: begin
        ctl.op    = wesd_pkg::OP_FIN3;
        state_nxt = S_EMIT;
      end
      S_REL: begin
        ctl.op    = wesd_pkg::OP_REL;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          ctl.op    = wesd_pkg::OP_EMIT;
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !out_ready) || emit;
  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/wesd_dp.sv @@
// ----------------------------------------------------------------------------
// wesd_dp
// Datapath: item and drag registers, proposal, peer delta fold, finish
// snapping, release click test and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wesd_dp #(
  parameter int COORD_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  wesd_pkg::ctl_t                       ctl,
  output wesd_pkg::status_t                    sts,
  input  logic [wesd_pkg::CMD_W-1:0]           in_cmd,
  input  logic [wesd_pkg::MODE_W-1:0]          in_mode,
  input  logic signed [COORD_BITS-1:0]         in_pointer_x,
  input  logic signed [COORD_BITS-1:0]         in_pointer_y,
  input  logic signed [COORD_BITS-1:0]         in_rect_x,
  input  logic signed [COORD_BITS-1:0]         in_rect_y,
  input  logic [COORD_BITS-1:0]                in_rect_w,
  input  logic [COORD_BITS-1:0]                in_rect_h,
  input  logic                                 cfg_we,
  input  logic [wesd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wesd_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic [wesd_pkg::KIND_W-1:0]          out_result_kind,
  output logic signed [COORD_BITS:0]           out_x,
  output logic signed [COORD_BITS:0]           out_y,
  output logic [COORD_BITS-1:0]                out_w,
  output logic [COORD_BITS-1:0]                out_h,
  output logic                                 out_is_click
);

  localparam int CB = COORD_BITS;
  localparam int WW = ((CB > 17) ? CB : 17) + 5;
  localparam int SQ_W = 2 * wesd_pkg::CLICK_BITS;

  typedef logic signed [WW-1:0] wv_t;

  function automatic wv_t mag(input wv_t v);
    mag = (v < 0) ? -v : v;
  endfunction

  function automatic wv_t closer(input wv_t cur, input wv_t cand);
    closer = (mag(cand) < mag(cur)) ? cand : cur;
  endfunction

  function automatic wv_t clampd(input wv_t v, input wv_t lo, input wv_t hi);
    wv_t t;
    t      = (v < lo) ? lo : v;
    clampd = (t > hi) ? hi : t;
  endfunction

  // configuration
  logic [wesd_pkg::SNAP_W-1:0]     snap_r;
  logic [wesd_pkg::CFG_DATA_W-1:0] scr_w_r, scr_h_r, min_r, max_r, thr_r;

  // drag control
  logic                        active_r;
  logic [wesd_pkg::MODE_W-1:0] dmode_r;

  // item
  logic [wesd_pkg::CMD_W-1:0]  it_cmd_r;
  logic [wesd_pkg::MODE_W-1:0] it_mode_r;
  logic signed [CB-1:0]        it_px_r, it_py_r, it_rx_r, it_ry_r;
  logic [CB-1:0]               it_rw_r, it_rh_r;

  // drag state
  logic signed [CB-1:0] opx_r, opy_r, sl_r, st_r;
  logic [CB-1:0]        stw_r, sth_r;
  wv_t                  p1_r, p2_r, bh_r, bv_r;
  wv_t                  ch_r [4];
  wv_t                  cv_r [4];
  logic                 near_h_r, near_v_r;
  wv_t                  fx_r, fy_r;
  wv_t                  rdx_r, rdy_r;
  logic [SQ_W-1:0]      sqx_r, sqy_r;
  logic                 small_r;
  logic signed [CB-1:0] ix_r, iy_r;

  // combinational
  wv_t e_px, e_py, e_rx, e_ry, e_rw, e_rh;
  wv_t e_sl, e_st, e_stw, e_sth, s, e_scrw, e_scrh, e_min, e_max;
  wv_t dx, dy;
  logic is_move, is_resize, is_icon, snap_on;
  wv_t px_x, px_y, px_r, px_b, orr, obb;
  logic near_h, near_v;
  wv_t fh1, fh2, fh3, fh4, fv1, fv2, fv3, fv4;
  logic ap_h, ap_v;
  wv_t rgt, btm;
  logic lsnap_x, lsnap_y, rsnap_x, rsnap_y;
  wv_t rx_new, ry_new;
  logic signed [wesd_pkg::CLICK_BITS-1:0] dx9, dy9;
  logic signed [SQ_W-1:0] sqx_s, sqy_s;
  wv_t ixs, iys;
  logic [SQ_W:0] sq_sum;
  logic click;
  wv_t src_x, src_y, src_w, src_h;
  logic [wesd_pkg::KIND_W-1:0] kind;
  wv_t lim_hi, lim_lo, smax;
  wv_t sat_x, sat_y, sat_w, sat_h;

  always_comb begin
    e_px   = wv_t'(it_px_r);
    e_py   = wv_t'(it_py_r);
    e_rx   = wv_t'(it_rx_r);
    e_ry   = wv_t'(it_ry_r);
    e_rw   = wv_t'(it_rw_r);
    e_rh   = wv_t'(it_rh_r);
    e_sl   = wv_t'(sl_r);
    e_st   = wv_t'(st_r);
    e_stw  = wv_t'(stw_r);
    e_sth  = wv_t'(sth_r);
    s      = wv_t'(snap_r);
    e_scrw = wv_t'(scr_w_r);
    e_scrh = wv_t'(scr_h_r);
    e_min  = wv_t'(min_r);
    e_max  = wv_t'(max_r);

    is_move   = (dmode_r == wesd_pkg::MODE_MOVE);
    is_resize = (dmode_r == wesd_pkg::MODE_RESIZE);
    is_icon   = (dmode_r == wesd_pkg::MODE_ICON);
    snap_on   = (snap_r != '0);

    dx = e_px - wv_t'(opx_r);
    dy = e_py - wv_t'(opy_r);

    // peer candidates
    px_x   = is_move ? p1_r : e_sl;
    px_y   = is_move ? p2_r : e_st;
    px_r   = px_x + (is_move ? e_stw : p1_r);
    px_b   = px_y + (is_move ? e_sth : p2_r);
    orr    = e_rx + e_rw;
    obb    = e_ry + e_rh;
    near_h = !((px_b < e_ry - s) || (obb < px_y - s));
    near_v = !((px_r < e_rx - s) || (orr < px_x - s));

    // fold, first offered wins ties
    fh1 = is_move ? closer(bh_r, ch_r[0]) : bh_r;
    fh2 = closer(fh1, ch_r[1]);
    fh3 = closer(fh2, ch_r[2]);
    fh4 = is_move ? closer(fh3, ch_r[3]) : fh3;
    fv1 = is_move ? closer(bv_r, cv_r[0]) : bv_r;
    fv2 = closer(fv1, cv_r[1]);
    fv3 = closer(fv2, cv_r[2]);
    fv4 = is_move ? closer(fv3, cv_r[3]) : fv3;

    // finish
    ap_h    = snap_on && !is_icon && (mag(bh_r) < s);
    ap_v    = snap_on && !is_icon && (mag(bv_r) < s);
    lsnap_x = snap_on && is_move && (scr_w_r != '0) && (mag(fx_r) <= s);
    lsnap_y = snap_on && is_move && (scr_h_r != '0) && (mag(fy_r) <= s);
    rgt     = is_move ? (fx_r + e_stw) : (e_sl + fx_r);
    btm     = is_move ? (fy_r + e_sth) : (e_st + fy_r);
    rsnap_x = snap_on && !is_icon && (scr_w_r != '0) && (mag(rgt - e_scrw) <= s);
    rsnap_y = snap_on && !is_icon && (scr_h_r != '0) && (mag(btm - e_scrh) <= s);
    rx_new  = is_move ? (e_scrw - e_stw) : (e_scrw - e_sl);
    ry_new  = is_move ? (e_scrh - e_sth) : (e_scrh - e_st);

    // release
    dx9    = rdx_r[wesd_pkg::CLICK_BITS-1:0];
    dy9    = rdy_r[wesd_pkg::CLICK_BITS-1:0];
    sqx_s  = dx9 * dx9;
    sqy_s  = dy9 * dy9;
    ixs    = e_sl + rdx_r;
    iys    = e_st + rdy_r;
    sq_sum = {1'b0, sqx_r} + {1'b0, sqy_r};
    click  = small_r && (sq_sum < (SQ_W+1)'(thr_r));

    // result sources
    if (it_cmd_r == wesd_pkg::CMD_RELEASE) begin
      kind  = wesd_pkg::KIND_RELEASE;
      src_x = click ? e_sl : wv_t'(ix_r);
      src_y = click ? e_st : wv_t'(iy_r);
      src_w = e_stw;
      src_h = e_sth;
    end else begin
      case (dmode_r)
        wesd_pkg::MODE_MOVE:   kind = wesd_pkg::KIND_MOVE;
        wesd_pkg::MODE_RESIZE: kind = wesd_pkg::KIND_RESIZE;
        default:               kind = wesd_pkg::KIND_ICON;
      endcase
      src_x = is_resize ? e_sl : fx_r;
      src_y = is_resize ? e_st : fy_r;
      src_w = is_resize ? fx_r : e_stw;
      src_h = is_resize ? fy_r : e_sth;
    end

    lim_hi = (wv_t'(1) <<< CB) - wv_t'(1);
    lim_lo = -(wv_t'(1) <<< CB);
    smax   = lim_hi;
    sat_x  = (src_x < lim_lo) ? lim_lo : ((src_x > lim_hi) ? lim_hi : src_x);
    sat_y  = (src_y < lim_lo) ? lim_lo : ((src_y > lim_hi) ? lim_hi : src_y);
    sat_w  = (src_w < 0) ? wv_t'(0) : ((src_w > smax) ? smax : src_w);
    sat_h  = (src_h < 0) ? wv_t'(0) : ((src_h > smax) ? smax : src_h);
  end

  assign sts.cmd       = it_cmd_r;
  assign sts.mode      = it_mode_r;
  assign sts.active    = active_r;
  assign sts.drag_mode = dmode_r;
  assign sts.snap_zero = !snap_on;

  // control and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      dmode_r  <= wesd_pkg::MODE_MOVE;
      snap_r   <= wesd_pkg::RST_SNAP_DISTANCE;
      scr_w_r  <= wesd_pkg::RST_SCREEN_WIDTH;
      scr_h_r  <= wesd_pkg::RST_SCREEN_HEIGHT;
      min_r    <= wesd_pkg::RST_MIN_DIMENSION;
      max_r    <= wesd_pkg::RST_MAX_DIMENSION;
      thr_r    <= wesd_pkg::RST_CLICK_THRESHOLD;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          wesd_pkg::REG_SNAP_DISTANCE:   snap_r  <= cfg_data[wesd_pkg::SNAP_W-1:0];
          wesd_pkg::REG_SCREEN_WIDTH:    scr_w_r <= cfg_data;
          wesd_pkg::REG_SCREEN_HEIGHT:   scr_h_r <= cfg_data;
          wesd_pkg::REG_MIN_DIMENSION:   min_r   <= cfg_data;
          wesd_pkg::REG_MAX_DIMENSION:   max_r   <= cfg_data;
          wesd_pkg::REG_CLICK_THRESHOLD: thr_r   <= cfg_data;
          default: ;
        endcase
      end
      if (ctl.op == wesd_pkg::OP_START) begin
        active_r <= 1'b1;
        dmode_r  <= it_mode_r;
      end else if (ctl.op == wesd_pkg::OP_END) begin
        active_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      wesd_pkg::OP_LOAD: begin
        it_cmd_r  <= in_cmd;
        it_mode_r <= in_mode;
        it_px_r   <= in_pointer_x;
        it_py_r   <= in_pointer_y;
        it_rx_r   <= in_rect_x;
        it_ry_r   <= in_rect_y;
        it_rw_r   <= in_rect_w;
        it_rh_r   <= in_rect_h;
      end
      wesd_pkg::OP_START: begin
        opx_r <= it_px_r;
        opy_r <= it_py_r;
        sl_r  <= it_rx_r;
        st_r  <= it_ry_r;
        stw_r <= it_rw_r;
        sth_r <= it_rh_r;
      end
      wesd_pkg::OP_MOTION: begin
        p1_r <= is_resize ? (e_stw + dx) : (e_sl + dx);
        p2_r <= is_resize ? (e_sth + dy) : (e_st + dy);
        bh_r <= s;
        bv_r <= s;
      end
      wesd_pkg::OP_CLAMP: begin
        if (is_resize) begin
          p1_r <= clampd(p1_r, e_min, e_max);
          p2_r <= clampd(p2_r, e_min, e_max);
        end
      end
      wesd_pkg::OP_PREP: begin
        near_h_r <= near_h;
        near_v_r <= near_v;
        ch_r[0]  <= orr - px_x;
        ch_r[1]  <= orr - px_r;
        ch_r[2]  <= e_rx - px_r;
        ch_r[3]  <= e_rx - px_x;
        cv_r[0]  <= obb - px_y;
        cv_r[1]  <= obb - px_b;
        cv_r[2]  <= e_ry - px_b;
        cv_r[3]  <= e_ry - px_y;
      end
      wesd_pkg::OP_FOLD: begin
        if (near_h_r) bh_r <= fh4;
        if (near_v_r) bv_r <= fv4;
      end
      wesd_pkg::OP_FIN1: begin
        fx_r <= p1_r + (ap_h ? bh_r : wv_t'(0));
        fy_r <= p2_r + (ap_v ? bv_r : wv_t'(0));
      end
      wesd_pkg::OP_FIN2: begin
        if (is_resize) begin
          if (ap_h) fx_r <= clampd(fx_r, e_min, e_max);
          if (ap_v) fy_r <= clampd(fy_r, e_min, e_max);
        end else begin
          if (lsnap_x) fx_r <= '0;
          if (lsnap_y) fy_r <= '0;
        end
      end
      wesd_pkg::OP_FIN3: begin
        if (rsnap_x) fx_r <= is_resize ? clampd(rx_new, e_min, e_max) : rx_new;
        if (rsnap_y) fy_r <= is_resize ? clampd(ry_new, e_min, e_max) : ry_new;
      end
      wesd_pkg::OP_END: begin
        rdx_r <= dx;
        rdy_r <= dy;
      end
      wesd_pkg::OP_REL: begin
        small_r <= (mag(rdx_r) < wv_t'(wesd_pkg::CLICK_SPAN)) &&
                   (mag(rdy_r) < wv_t'(wesd_pkg::CLICK_SPAN));
        sqx_r   <= unsigned'(sqx_s);
        sqy_r   <= unsigned'(sqy_s);
        ix_r    <= ixs[CB-1:0];
        iy_r    <= iys[CB-1:0];
      end
      wesd_pkg::OP_EMIT: begin
        out_result_kind <= kind;
        out_x           <= sat_x[CB:0];
        out_y           <= sat_y[CB:0];
        out_w           <= sat_w[CB-1:0];
        out_h           <= sat_h[CB-1:0];
        out_is_click    <= (it_cmd_r == wesd_pkg::CMD_RELEASE) && click;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ sv/window_edge_snap_drag.sv @@
// Steps: an item is taken when the block is idle, loaded and decoded in exec; start
//   and motion items go on to motion and clamp, a peer rectangle to fold, others end.
// Finish: result registered in emit after the FIN1, FIN2, FIN3 steps; icon release: after REL.
// Throughput: one item at a time, set by the step sequence of the controller;
//   a stalled result holds a finish or icon release in its emit step.
// Reset: synchronous active-low; drag inactive, registers to defaults, no sweep.
// ----------------------------------------------------------------------------
// window_edge_snap_drag
// Drag geometry engine with peer edge snapping and screen edge snapping.
// ----------------------------------------------------------------------------
`default_nettype none

module window_edge_snap_drag #(
  parameter int COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  wesd_in_if.sink     in_if,
  wesd_out_if.source  out_if,
  wesd_cfg_if.sink    cfg_if
);

  wesd_pkg::ctl_t    ctl;
  wesd_pkg::status_t sts;
  logic              in_ready;
  logic              out_valid;

  assign in_if.ready  = in_ready;
  assign out_if.valid = out_valid;
  assign cfg_if.ready = 1'b1;

  wesd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  wesd_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .sts             (sts),
    .in_cmd          (in_if.cmd),
    .in_mode         (in_if.mode),
    .in_pointer_x    (in_if.pointer_x),
    .in_pointer_y    (in_if.pointer_y),
    .in_rect_x       (in_if.rect_x),
    .in_rect_y       (in_if.rect_y),
    .in_rect_w       (in_if.rect_w),
    .in_rect_h       (in_if.rect_h),
    .cfg_we          (cfg_if.valid),
    .cfg_index       (cfg_if.index),
    .cfg_data        (cfg_if.data),
    .out_result_kind (out_if.result_kind),
    .out_x           (out_if.out_x),
    .out_y           (out_if.out_y),
    .out_w           (out_if.out_w),
    .out_h           (out_if.out_h),
    .out_is_click    (out_if.is_click)
  );

endmodule

`default_nettype wire

@@ sv/wesd_checker.sv @@
// ----------------------------------------------------------------------------
// wesd_checker
// Port-level checks for the drag engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wesd_checker #(
  parameter int COORD_BITS = 16
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [wesd_pkg::KIND_W-1:0]   result_kind,
  input logic [COORD_BITS:0]           out_x,
  input logic [COORD_BITS:0]           out_y,
  input logic [COORD_BITS-1:0]         out_w,
  input logic [COORD_BITS-1:0]         out_h,
  input logic                          is_click
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(result_kind) && $stable(out_x) &&
    $stable(out_y) && $stable(out_w) && $stable(out_h) && $stable(is_click))
    else $error("result changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_click_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_click |-> result_kind == wesd_pkg::KIND_RELEASE)
    else $error("click flag on a non-release result");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("not idle after reset");

endmodule

bind window_edge_snap_drag wesd_checker #(
  .COORD_BITS (COORD_BITS)
) u_wesd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .result_kind (out_if.result_kind),
  .out_x       (out_if.out_x),
  .out_y       (out_if.out_y),
  .out_w       (out_if.out_w),
  .out_h       (out_if.out_h),
  .is_click    (out_if.is_click)
);

`default_nettype wire

@@ dv/tb_window_edge_snap_drag.sv @@
// ----------------------------------------------------------------------------
// tb_window_edge_snap_drag
// Self-checking bench for the drag geometry engine. A directed drag sequence
// is followed by random drag sessions under several register settings. An
// in-bench predictor tracks drag state and best snap deltas and checks every
// result transfer field by field against the oldest expected result.
// ----------------------------------------------------------------------------

module tb_window_edge_snap_drag;
  timeunit 1ns;
  timeprecision 1ps;

  import wesd_pkg::*;

  localparam int CB          = 16;
  localparam int STALL_LIMIT = 1000;
  localparam int SETTLE      = 12;
  localparam int PHASE_ITEMS = 140;
  localparam logic [CMD_W-1:0] CMD_SPARE = '1;

  typedef struct packed {
    logic [CMD_W-1:0]      cmd;
    logic [MODE_W-1:0]     mode;
    logic signed [CB-1:0]  pointer_x;
    logic signed [CB-1:0]  pointer_y;
    logic signed [CB-1:0]  rect_x;
    logic signed [CB-1:0]  rect_y;
    logic [CB-1:0]         rect_w;
    logic [CB-1:0]         rect_h;
  } drag_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic signed [CB:0]    x;
    logic signed [CB:0]    y;
    logic [CB-1:0]         w;
    logic [CB-1:0]         h;
    logic                  click;
  } drag_result_t;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_QUARTER, SINK_SPARSE} sink_style_t;

  logic clk;
  logic rst_n;

  wesd_in_if  #(.COORD_BITS(CB)) in_if ();
  wesd_out_if #(.COORD_BITS(CB)) out_if ();
  wesd_cfg_if                    cfg_if ();

  window_edge_snap_drag #(.COORD_BITS(CB)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  drag_item_t   pending_items[$];
  drag_result_t expected_geometry[$];
  drag_item_t   head_item;
  drag_result_t want;
  int           mismatches;
  int           posted;
  int           burst_left;
  int           gap_left;
  int           idle_cycles;
  int           sink_left;
  int           sink_tick;
  sink_style_t  sink_style;

  // predictor configuration and drag state
  longint reg_snap, reg_scr_w, reg_scr_h, reg_min, reg_max, reg_click;
  bit          drag_on;
  logic [1:0]  drag_kind;
  longint org_px, org_py, base_left, base_top, base_w, base_h;
  longint prop_a, prop_b, keep_dh, keep_dv;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint nearer(longint cur, longint cand);
    return (mag(cand) < mag(cur)) ? cand : cur;
  endfunction

  function automatic bit spans_meet(longint a0, longint a1, longint b0, longint b1,
                                    longint s);
    return !(a1 < b0 - s || b1 < a0 - s);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint clamp_size(longint v);
    if (v < reg_min) v = reg_min;
    if (v > reg_max) v = reg_max;
    return v;
  endfunction

  function automatic drag_result_t shape_result(logic [1:0] k, longint x, longint y,
                                                longint w, longint h, bit click);
    drag_result_t r;
    longint lim;
    lim = longint'(1) << CB;
    r.kind  = k;
    r.x     = (CB+1)'(clip(x, -lim, lim - 1));
    r.y     = (CB+1)'(clip(y, -lim, lim - 1));
    r.w     = CB'(clip(w, 0, lim - 1));
    r.h     = CB'(clip(h, 0, lim - 1));
    r.click = click;
    return r;
  endfunction

  task automatic aim_proposal(longint px, longint py);
    longint dx, dy;
    dx = px - org_px;
    dy = py - org_py;
    if (drag_kind == MODE_RESIZE) begin
      prop_a = clamp_size(base_w + dx);
      prop_b = clamp_size(base_h + dy);
    end else begin
      prop_a = base_left + dx;
      prop_b = base_top + dy;
    end
    keep_dh = reg_snap;
    keep_dv = reg_snap;
  endtask

  task automatic apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_SNAP_DISTANCE:   reg_snap  = data[SNAP_W-1:0];
      REG_SCREEN_WIDTH:    reg_scr_w = data;
      REG_SCREEN_HEIGHT:   reg_scr_h = data;
      REG_MIN_DIMENSION:   reg_min   = data;
      REG_MAX_DIMENSION:   reg_max   = data;
      REG_CLICK_THRESHOLD: reg_click = data;
      default: ;
    endcase
  endtask

  task automatic fold_item(drag_item_t it);
    longint px, py, rx, ry, rw, rh, s, sw, sh;
    longint x, y, rt, bt, ort, obt, d, dx, dy, w, h;
    logic signed [CB-1:0] wrap_x, wrap_y;
    bit click;
    px = $signed(it.pointer_x);
    py = $signed(it.pointer_y);
    rx = $signed(it.rect_x);
    ry = $signed(it.rect_y);
    rw = it.rect_w;
    rh = it.rect_h;
    s  = reg_snap;
    sw = reg_scr_w;
    sh = reg_scr_h;
    if (it.cmd == CMD_START) begin
      if (it.mode != MODE_BAD) begin
        drag_on   = 1'b1;
        drag_kind = it.mode;
        org_px    = px;
        org_py    = py;
        base_left = rx;
        base_top  = ry;
        base_w    = rw;
        base_h    = rh;
        aim_proposal(px, py);
      end
    end else if (drag_on && it.cmd <= CMD_RELEASE) begin
      case (it.cmd)
        CMD_MOTION: aim_proposal(px, py);
        CMD_PEER: begin
          if (drag_kind != MODE_ICON && s != 0) begin
            ort = rx + rw;
            obt = ry + rh;
            if (drag_kind == MODE_MOVE) begin
              x  = prop_a;
              y  = prop_b;
              rt = x + base_w;
              bt = y + base_h;
            end else begin
              x  = base_left;
              y  = base_top;
              rt = x + prop_a;
              bt = y + prop_b;
            end
            if (spans_meet(y, bt, ry, obt, s)) begin
              d = keep_dh;
              if (drag_kind == MODE_MOVE) d = nearer(d, ort - x);
              d = nearer(d, ort - rt);
              d = nearer(d, rx - rt);
              if (drag_kind == MODE_MOVE) d = nearer(d, rx - x);
              keep_dh = d;
            end
            if (spans_meet(x, rt, rx, ort, s)) begin
              d = keep_dv;
              if (drag_kind == MODE_MOVE) d = nearer(d, obt - y);
              d = nearer(d, obt - bt);
              d = nearer(d, ry - bt);
              if (drag_kind == MODE_MOVE) d = nearer(d, ry - y);
              keep_dv = d;
            end
          end
        end
        CMD_FINISH: begin
          if (drag_kind == MODE_ICON) begin
            expected_geometry.push_back(
              shape_result(KIND_ICON, prop_a, prop_b, base_w, base_h, 1'b0));
          end else if (drag_kind == MODE_MOVE) begin
            x  = prop_a;
            y  = prop_b;
            rt = x + base_w;
            bt = y + base_h;
            if (s > 0) begin
              if (mag(keep_dh) < s) begin
                x  += keep_dh;
                rt += keep_dh;
              end
              if (mag(keep_dv) < s) begin
                y  += keep_dv;
                bt += keep_dv;
              end
              if (sw > 0 && mag(x) <= s) begin
                rt -= x;
                x = 0;
              end
              if (sh > 0 && mag(y) <= s) begin
                bt -= y;
                y = 0;
              end
              if (sw > 0 && mag(rt - sw) <= s) x = sw - base_w;
              if (sh > 0 && mag(bt - sh) <= s) y = sh - base_h;
            end
            expected_geometry.push_back(shape_result(KIND_MOVE, x, y, base_w, base_h, 1'b0));
          end else begin
            w  = prop_a;
            h  = prop_b;
            rt = base_left + w;
            bt = base_top + h;
            if (s > 0) begin
              if (mag(keep_dh) < s) begin
                w  = clamp_size(w + keep_dh);
                rt = base_left + w;
              end
              if (mag(keep_dv) < s) begin
                h  = clamp_size(h + keep_dv);
                bt = base_top + h;
              end
              if (sw > 0 && mag(rt - sw) <= s) w = clamp_size(sw - base_left);
              if (sh > 0 && mag(bt - sh) <= s) h = clamp_size(sh - base_top);
            end
            expected_geometry.push_back(
              shape_result(KIND_RESIZE, base_left, base_top, w, h, 1'b0));
          end
        end
        default: begin
          drag_on = 1'b0;
          if (drag_kind == MODE_ICON) begin
            dx    = px - org_px;
            dy    = py - org_py;
            click = 1'b0;
            if (mag(dx) < CLICK_SPAN && mag(dy) < CLICK_SPAN)
              click = (dx * dx + dy * dy) < reg_click;
            if (click) begin
              expected_geometry.push_back(
                shape_result(KIND_RELEASE, base_left, base_top, base_w, base_h, 1'b1));
            end else begin
              wrap_x = CB'(base_left + dx);
              wrap_y = CB'(base_top + dy);
              expected_geometry.push_back(
                shape_result(KIND_RELEASE, wrap_x, wrap_y, base_w, base_h, 1'b0));
            end
          end
        end
      endcase
    end
  endtask

  // predictor update and result checking
  always @(posedge clk) begin
    if (!rst_n) begin
      reg_snap  = RST_SNAP_DISTANCE;
      reg_scr_w = RST_SCREEN_WIDTH;
      reg_scr_h = RST_SCREEN_HEIGHT;
      reg_min   = RST_MIN_DIMENSION;
      reg_max   = RST_MAX_DIMENSION;
      reg_click = RST_CLICK_THRESHOLD;
      drag_on   = 1'b0;
      drag_kind = MODE_MOVE;
      {org_px, org_py, base_left, base_top, base_w, base_h} = '0;
      {prop_a, prop_b, keep_dh, keep_dv} = '0;
      expected_geometry.delete();
    end else begin
      if (cfg_if.valid && cfg_if.ready) apply_reg(cfg_if.index, cfg_if.data);
      if (in_if.valid && in_if.ready)
        fold_item('{in_if.cmd, in_if.mode, in_if.pointer_x, in_if.pointer_y,
                    in_if.rect_x, in_if.rect_y, in_if.rect_w, in_if.rect_h});
      if (out_if.valid && out_if.ready) begin
        if (expected_geometry.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d x %h y %h",
                                    out_if.result_kind, out_if.out_x, out_if.out_y));
        end else begin
          want = expected_geometry.pop_front();
          if (out_if.result_kind !== want.kind)
            report_mismatch($sformatf("kind got %0d want %0d", out_if.result_kind, want.kind));
          if (out_if.out_x !== want.x)
            report_mismatch($sformatf("out_x got %h want %h", out_if.out_x, want.x));
          if (out_if.out_y !== want.y)
            report_mismatch($sformatf("out_y got %h want %h", out_if.out_y, want.y));
          if (out_if.out_w !== want.w)
            report_mismatch($sformatf("out_w got %h want %h", out_if.out_w, want.w));
          if (out_if.out_h !== want.h)
            report_mismatch($sformatf("out_h got %h want %h", out_if.out_h, want.h));
          if (out_if.is_click !== want.click)
            report_mismatch($sformatf("is_click got %b want %b", out_if.is_click, want.click));
        end
      end
    end
  end

  // input driver: bursts with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      burst_left  <= 1;
      gap_left    <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (gap_left != 0) begin
        in_if.valid <= 1'b0;
        gap_left    <= gap_left - 1;
      end else if (pending_items.size() != 0) begin
        head_item = pending_items.pop_front();
        in_if.valid     <= 1'b1;
        in_if.cmd       <= head_item.cmd;
        in_if.mode      <= head_item.mode;
        in_if.pointer_x <= head_item.pointer_x;
        in_if.pointer_y <= head_item.pointer_y;
        in_if.rect_x    <= head_item.rect_x;
        in_if.rect_y    <= head_item.rect_y;
        in_if.rect_w    <= head_item.rect_w;
        in_if.rect_h    <= head_item.rect_h;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result sink stall patterns
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      sink_style   <= SINK_OPEN;
      sink_left    <= 0;
      sink_tick    <= 0;
    end else begin
      sink_tick <= sink_tick + 1;
      if (sink_left == 0) begin
        sink_style <= sink_style_t'($urandom_range(0, 3));
        sink_left  <= $urandom_range(20, 150);
      end else begin
        sink_left <= sink_left - 1;
      end
      case (sink_style)
        SINK_OPEN:    out_if.ready <= 1'b1;
        SINK_COIN:    out_if.ready <= $urandom_range(0, 1);
        SINK_QUARTER: out_if.ready <= (sink_tick % 4 == 0);
        default:      out_if.ready <= (sink_tick % 13 == 0);
      endcase
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic program_regs(int snap, int sw, int sh, int mn, int mx, int thr);
    write_reg(REG_SNAP_DISTANCE, {6'($urandom), 10'(snap)});
    write_reg(REG_SCREEN_WIDTH, 16'(sw));
    write_reg(REG_SCREEN_HEIGHT, 16'(sh));
    write_reg(REG_MIN_DIMENSION, 16'(mn));
    write_reg(REG_MAX_DIMENSION, 16'(mx));
    write_reg(REG_CLICK_THRESHOLD, 16'(thr));
    @(negedge clk);
  endtask

  task automatic wait_for_idle();
    @(negedge clk);
    while (pending_items.size() != 0 || in_if.valid || expected_geometry.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic post(int c, int m, int px, int py, int rx, int ry, int rw, int rh);
    drag_item_t t;
    t.cmd       = c[CMD_W-1:0];
    t.mode      = m[MODE_W-1:0];
    t.pointer_x = px[CB-1:0];
    t.pointer_y = py[CB-1:0];
    t.rect_x    = rx[CB-1:0];
    t.rect_y    = ry[CB-1:0];
    t.rect_w    = rw[CB-1:0];
    t.rect_h    = rh[CB-1:0];
    pending_items.push_back(t);
    if (c <= CMD_RELEASE) posted++;
  endtask

  function automatic int spread(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic int pick_travel();
    case ($urandom_range(0, 3))
      0:       return spread(4);
      1:       return spread(40);
      2:       return spread(600);
      default: return spread(3000);
    endcase
  endfunction

  // one drag: start, motions with peers and finishes, then release
  task automatic queue_drag_session();
    int m, px, py, rx, ry, rw, rh, dx, dy, wl, wt, ww, wh, jit, pl, pt, pw, ph;
    bit wide;
    wide = ($urandom_range(0, 7) == 0);
    m    = ($urandom_range(0, 15) == 0) ? int'(MODE_BAD) : int'($urandom_range(0, 2));
    jit  = int'(reg_snap) + 4;
    dx   = 0;
    dy   = 0;
    if (wide) begin
      px = $urandom;
      py = $urandom;
      rx = $urandom;
      ry = $urandom;
      rw = $urandom;
      rh = $urandom;
    end else begin
      rw = $urandom_range(1, 400);
      rh = $urandom_range(1, 400);
      px = $urandom_range(0, 2000);
      py = $urandom_range(0, 2000);
      case ($urandom_range(0, 2))
        0: begin
          rx = spread(jit);
          ry = spread(jit);
        end
        1: begin
          rx = int'(reg_scr_w) - rw + spread(jit);
          ry = int'(reg_scr_h) - rh + spread(jit);
        end
        default: begin
          rx = int'($urandom_range(0, 3000)) - 500;
          ry = int'($urandom_range(0, 3000)) - 500;
        end
      endcase
    end
    post(CMD_START, m, px, py, rx, ry, rw, rh);
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 3) != 0) begin
        dx = wide ? int'($urandom) : pick_travel();
        dy = wide ? int'($urandom) : pick_travel();
        post(CMD_MOTION, $urandom, px + dx, py + dy, $urandom, $urandom, $urandom, $urandom);
      end
      if (m == MODE_RESIZE) begin
        wl = rx;
        wt = ry;
        ww = rw + dx;
        wh = rh + dy;
      end else begin
        wl = rx + dx;
        wt = ry + dy;
        ww = rw;
        wh = rh;
      end
      repeat ($urandom_range(0, 6)) begin
        if ($urandom_range(0, 5) == 0) begin
          post(CMD_PEER, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else begin
          pw = $urandom_range(0, 300);
          ph = $urandom_range(0, 300);
          case ($urandom_range(0, 3))
            0:       pl = wl - pw;
            1:       pl = wl + ww;
            2:       pl = wl;
            default: pl = wl + ww - pw;
          endcase
          case ($urandom_range(0, 3))
            0:       pt = wt - ph;
            1:       pt = wt + wh;
            2:       pt = wt;
            default: pt = wt + wh - ph;
          endcase
          post(CMD_PEER, $urandom, $urandom, $urandom, pl + spread(jit), pt + spread(jit),
               pw, ph);
        end
      end
      if ($urandom_range(0, 9) != 0)
        post(CMD_FINISH, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
    if ($urandom_range(0, 9) != 0) begin
      if ($urandom_range(0, 1) == 0)
        post(CMD_RELEASE, $urandom, px + spread(5), py + spread(5),
             $urandom, $urandom, $urandom, $urandom);
      else
        post(CMD_RELEASE, $urandom, px + dx + spread(3), py + dy + spread(3),
             $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.cmd       = CMD_START;
    in_if.mode      = MODE_MOVE;
    in_if.pointer_x = '0;
    in_if.pointer_y = '0;
    in_if.rect_x    = '0;
    in_if.rect_y    = '0;
    in_if.rect_w    = '0;
    in_if.rect_h    = '0;
    out_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = REG_SNAP_DISTANCE;
    cfg_if.data     = '0;
    mismatches      = 0;
    posted          = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    program_regs(8, 1920, 1080, 10, 4000, 16);
    // inactive drag, bad mode and spare command are all dropped
    post(CMD_RELEASE, MODE_MOVE, 5, 5, 0, 0, 0, 0);
    post(CMD_START, MODE_BAD, 1, 1, 1, 1, 1, 1);
    post(CMD_SPARE, MODE_BAD, -1, -1, -1, -1, 65535, 65535);
    // move: finish with no motion, then a tie between two peers
    post(CMD_START, MODE_MOVE, 100, 100, 50, 50, 200, 100);
    post(CMD_FINISH, MODE_MOVE, 0, 0, 0, 0, 0, 0);
    post(CMD_MOTION, MODE_MOVE, 103, 98, 0, 0, 0, 0);
    post(CMD_PEER, MODE_MOVE, 0, 0, 256, 40, 100, 100);
    post(CMD_PEER, MODE_MOVE, 0, 0, 0, 60, 50, 80);
    post(CMD_FINISH, MODE_MOVE, 0, 0, 0, 0, 0, 0);
    post(CMD_RELEASE, MODE_MOVE, 103, 98, 0, 0, 0, 0);
    // resize against both clamp bounds
    post(CMD_START, MODE_RESIZE, 0, 0, 100, 100, 300, 200);
    post(CMD_MOTION, MODE_RESIZE, -1000, -1000, 0, 0, 0, 0);
    post(CMD_FINISH, MODE_RESIZE, 0, 0, 0, 0, 0, 0);
    post(CMD_MOTION, MODE_RESIZE, 32767, 32767, 0, 0, 0, 0);
    post(CMD_PEER, MODE_RESIZE, 0, 0, 4105, 100, 50, 50);
    post(CMD_FINISH, MODE_RESIZE, 0, 0, 0, 0, 0, 0);
    post(CMD_RELEASE, MODE_RESIZE, 0, 0, 0, 0, 0, 0);
    // icon: peer ignored, unsnapped finish, click release
    post(CMD_START, MODE_ICON, 10, 10, 500, 500, 64, 64);
    post(CMD_PEER, MODE_ICON, 0, 0, 498, 498, 10, 10);
    post(CMD_MOTION, MODE_ICON, 20, 20, 0, 0, 0, 0);
    post(CMD_FINISH, MODE_ICON, 0, 0, 0, 0, 0, 0);
    post(CMD_RELEASE, MODE_ICON, 12, 11, 0, 0, 0, 0);
    // icon release with wrapped position at field extremes
    post(CMD_START, MODE_ICON, -32768, -32768, 32767, 32767, 65535, 65535);
    post(CMD_RELEASE, MODE_ICON, 32767, 32767, 0, 0, 0, 0);
    // move saturating on the negative side
    post(CMD_START, MODE_MOVE, 32767, 32767, -32768, -32768, 65535, 65535);
    post(CMD_MOTION, MODE_MOVE, -32768, -32768, 0, 0, 0, 0);
    post(CMD_FINISH, MODE_MOVE, 0, 0, 0, 0, 0, 0);
    post(CMD_RELEASE, MODE_MOVE, 0, 0, 0, 0, 0, 0);
    wait_for_idle();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: program_regs(0, $urandom_range(0, 4000), $urandom_range(0, 4000), 1, 65535, 16);
        1: program_regs(1023, 65535, 65535, 1, 65535, 0);
        2: program_regs($urandom_range(1, 32), 0, 0, 500, 100, 65535);
        3: program_regs($urandom_range(1, 64), $urandom_range(1280, 2560),
                        $urandom_range(720, 1600), $urandom_range(1, 50),
                        $urandom_range(300, 5000), $urandom_range(0, 200));
        4: program_regs(1, 1920, 1080, 65535, 65535, $urandom_range(0, 65535));
        default: program_regs($urandom_range(2, 200), $urandom_range(0, 65535),
                              $urandom_range(0, 65535), $urandom_range(1, 100),
                              $urandom_range(1, 65535), $urandom_range(0, 65535));
      endcase
      posted = 0;
      while (posted < PHASE_ITEMS) begin
        if ($urandom_range(0, 11) == 0)
          post($urandom_range(0, 7), $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom);
        else
          queue_drag_session();
      end
      wait_for_idle();
    end

    if (mismatches == 0 && expected_geometry.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/wesd_pkg.sv
sv/wesd_if.sv
sv/wesd_ctrl.sv
sv/wesd_dp.sv
sv/window_edge_snap_drag.sv
sv/wesd_checker.sv
dv/tb_window_edge_snap_drag.sv
